>>> rtl/pgm_pkg.sv
// pgm_pkg: shared types and constants of the path glob matcher.
// Holds the transaction structs, the op codes, the engine state type and
// the special pattern characters. No dependencies.
`timescale 1ns / 1ps

package pgm_pkg;

    // Operation carried by an input transaction
    typedef enum logic [1:0] {
        OP_APPEND_PAT = 2'd0,
        OP_APPEND_TXT = 2'd1,
        OP_CLEAR      = 2'd2,
        OP_EVAL       = 2'd3
    } t_op;

    // Input transaction
    typedef struct packed {
        t_op        op;
        logic [7:0] char_code;
    } t_in_item;

    // Result transaction
    typedef struct packed {
        logic matched;
        logic overflow;
    } t_out_item;

    // Match engine states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CMP,
        ST_STAR,
        ST_BACK,
        ST_TAILF,
        ST_TAILC,
        ST_DONE
    } t_state;

    // Special pattern characters
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // Command queue between front and engine
    localparam int QDEPTH = 4;

endpackage

>>> rtl/pgm_front.sv
// pgm_front: input side of the matcher; a short command queue that takes
// transactions from the push/full port and hands them to the engine.
// Depends on pgm_pkg.
`timescale 1ns / 1ps

module pgm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  pgm_pkg::t_in_item i_item,
    output logic              o_cmd_valid,
    output pgm_pkg::t_in_item o_cmd,
    input  logic              i_cmd_ready
);
    import pgm_pkg::*;

    localparam int PW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    t_in_item        r_buf [QDEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic            wr_en, rd_en;

    assign full        = (r_count == CW'(QDEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_buf[r_rd_ptr];
    assign wr_en       = push && !full;
    assign rd_en       = o_cmd_valid && i_cmd_ready;

    // Pointer and occupancy update
    always_comb begin
        n_wr_ptr = wr_en ? r_wr_ptr + PW'(1) : r_wr_ptr;
        n_rd_ptr = rd_en ? r_rd_ptr + PW'(1) : r_rd_ptr;
        n_count  = r_count;
        if (wr_en && !rd_en) begin
            n_count = r_count + CW'(1);
        end else if (rd_en && !wr_en) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_buf[r_wr_ptr] <= i_item;
        end
    end

endmodule

>>> rtl/pgm_engine.sv
// pgm_engine: back part of the matcher; owns the pattern and text buffers,
// executes appends and clears, and runs the backtracking glob match.
// Depends on pgm_pkg.
`timescale 1ns / 1ps

module pgm_engine #(
    parameter int PATTERN_DEPTH = 64,
    parameter int TEXT_DEPTH    = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  pgm_pkg::t_in_item  i_cmd,
    output logic               o_cmd_ready,
    output logic               o_res_valid,
    output pgm_pkg::t_out_item o_res,
    input  logic               i_res_ready
);
    import pgm_pkg::*;

    localparam int PAW = $clog2(PATTERN_DEPTH);
    localparam int PLW = $clog2(PATTERN_DEPTH + 1);
    localparam int TAW = $clog2(TEXT_DEPTH);
    localparam int TLW = $clog2(TEXT_DEPTH + 1);

    // Buffers
    logic [7:0] r_pmem [PATTERN_DEPTH];
    logic [7:0] r_tmem [TEXT_DEPTH];
    logic [7:0] r_pdata, r_tdata;

    t_state         r_state, n_state;
    logic [PLW-1:0] r_plen, n_plen;
    logic [TLW-1:0] r_tlen, n_tlen;
    logic           r_ovf, n_ovf;
    logic [PLW-1:0] r_p, n_p;
    logic [TLW-1:0] r_t, n_t;
    logic [PLW-1:0] r_rp, n_rp;
    logic [TLW-1:0] r_rt, n_rt;
    logic           r_have_star, n_have_star;
    logic           r_dbl, n_dbl;
    logic           r_match, n_match;

    logic           p_we, t_we;
    logic [PAW-1:0] p_addr;
    logic [TAW-1:0] t_addr;
    logic           p_lt, t_lt;
    logic [PLW-1:0] p_inc;
    logic [TLW-1:0] t_inc, rt_inc;
    logic           chr_hit;
    logic           star_dbl;

    assign p_lt     = (r_p < r_plen);
    assign t_lt     = (r_t < r_tlen);
    assign p_inc    = r_p + PLW'(1);
    assign t_inc    = r_t + TLW'(1);
    assign rt_inc   = r_rt + TLW'(1);
    // '?' takes any non-slash byte; any other byte must match exactly
    assign chr_hit  = (r_pdata == CH_QMARK) ? (r_tdata != CH_SLASH) : (r_pdata == r_tdata);
    assign star_dbl = (p_inc < r_plen) && (r_pdata == CH_STAR);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && i_cmd.op == OP_EVAL) begin
                    n_state = r_ovf ? ST_DONE : ST_FETCH;
                end
            end
            ST_FETCH: n_state = t_lt ? ST_CMP : ST_TAILF;
            ST_CMP: begin
                if (p_lt && r_pdata == CH_STAR) begin
                    n_state = ST_STAR;
                end else if (p_lt && chr_hit) begin
                    n_state = ST_FETCH;
                end else if (!r_have_star) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_BACK;
                end
            end
            ST_STAR: n_state = ST_FETCH;
            ST_BACK: begin
                n_state = (!r_dbl && r_tdata == CH_SLASH) ? ST_DONE : ST_FETCH;
            end
            ST_TAILF: n_state = p_lt ? ST_TAILC : ST_DONE;
            ST_TAILC: n_state = (r_pdata == CH_STAR) ? ST_TAILF : ST_DONE;
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and buffer control
    always_comb begin
        n_plen      = r_plen;
        n_tlen      = r_tlen;
        n_ovf       = r_ovf;
        n_p         = r_p;
        n_t         = r_t;
        n_rp        = r_rp;
        n_rt        = r_rt;
        n_have_star = r_have_star;
        n_dbl       = r_dbl;
        n_match     = r_match;
        p_we        = 1'b0;
        t_we        = 1'b0;
        p_addr      = r_p[PAW-1:0];
        t_addr      = r_t[TAW-1:0];
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        OP_APPEND_PAT: begin
                            if (r_plen < PLW'(PATTERN_DEPTH)) begin
                                p_we   = 1'b1;
                                n_plen = r_plen + PLW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        OP_APPEND_TXT: begin
                            if (r_tlen < TLW'(TEXT_DEPTH)) begin
                                t_we   = 1'b1;
                                n_tlen = r_tlen + TLW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_plen = '0;
                            n_tlen = '0;
                            n_ovf  = 1'b0;
                        end
                        OP_EVAL: begin
                            n_match     = 1'b0;
                            n_p         = '0;
                            n_t         = '0;
                            n_rp        = '0;
                            n_rt        = '0;
                            n_have_star = 1'b0;
                            n_dbl       = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CMP: begin
                if (p_lt && r_pdata == CH_STAR) begin
                    // look one ahead for a double star
                    p_addr = p_inc[PAW-1:0];
                end else if (p_lt && chr_hit) begin
                    n_p = p_inc;
                    n_t = t_inc;
                end else if (!r_have_star) begin
                    n_match = 1'b0;
                end else begin
                    t_addr = r_rt[TAW-1:0];
                end
            end
            ST_STAR: begin
                n_p         = star_dbl ? r_p + PLW'(2) : p_inc;
                n_rp        = star_dbl ? r_p + PLW'(2) : p_inc;
                n_rt        = r_t;
                n_have_star = 1'b1;
                n_dbl       = star_dbl;
            end
            ST_BACK: begin
                // a single star may not swallow a slash
                if (!r_dbl && r_tdata == CH_SLASH) begin
                    n_match = 1'b0;
                end else begin
                    n_p  = r_rp;
                    n_rt = rt_inc;
                    n_t  = rt_inc;
                end
            end
            ST_TAILF: begin
                if (!p_lt) begin
                    n_match = 1'b1;
                end
            end
            ST_TAILC: begin
                if (r_pdata == CH_STAR) begin
                    n_p = p_inc;
                end else begin
                    n_match = 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign o_cmd_ready = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_res       = '{matched: r_match, overflow: r_ovf};

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_plen      <= '0;
            r_tlen      <= '0;
            r_ovf       <= 1'b0;
            r_have_star <= 1'b0;
            r_dbl       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_plen      <= n_plen;
            r_tlen      <= n_tlen;
            r_ovf       <= n_ovf;
            r_have_star <= n_have_star;
            r_dbl       <= n_dbl;
        end
    end

    // Walk positions and result bit
    always_ff @(posedge i_clk) begin
        r_p     <= n_p;
        r_t     <= n_t;
        r_rp    <= n_rp;
        r_rt    <= n_rt;
        r_match <= n_match;
    end

    // Pattern buffer: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (p_we) begin
            r_pmem[r_plen[PAW-1:0]] <= i_cmd.char_code;
        end
        r_pdata <= r_pmem[p_addr];
    end

    // Text buffer: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (t_we) begin
            r_tmem[r_tlen[TAW-1:0]] <= i_cmd.char_code;
        end
        r_tdata <= r_tmem[t_addr];
    end

    // Lengths never pass the buffer capacity
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_plen <= PLW'(PATTERN_DEPTH)) && (r_tlen <= TLW'(TEXT_DEPTH)))
        else $error("buffer length beyond capacity");

    // An overflowed evaluate never reports a match
    a_ovf_nomatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && r_ovf) |-> !r_match)
        else $error("match reported with overflow");

    // Compare only runs on a text position inside the text
    a_cmp_in_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP || r_state == ST_BACK) |-> (t_lt && r_rt <= r_t))
        else $error("text position out of range during compare");

    // A waiting result holds until taken
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=> (o_res_valid && $stable(o_res)))
        else $error("result dropped or changed while stalled");

endmodule

>>> rtl/path_glob_matcher.sv
// path_glob_matcher: top level; command queue front, match engine back,
// and a one-entry result register toward the pop side.
// Depends on pgm_pkg, pgm_front and pgm_engine.
//
// Usage: write transactions through push/full. op selects append to the
// pattern buffer, append to the text buffer, clear both, or evaluate.
// Only evaluate produces a result, read through empty/pop: matched is set
// when the whole text matches the whole pattern, overflow when an append
// hit a full buffer since the last clear (matched is then 0).
// Timing: a four-entry queue takes transactions while the engine works.
// Appends and clears are done in the engine's idle state. An evaluate
// takes a fetch and a compare state per character step, one more state per
// star or backtrack step, and a tail fetch and check per trailing pattern
// star, as each buffer has a single read port; a backtracking walk can
// reach pattern length times text length steps. o_result is registered.
// Reset clears the lengths, the overflow flag, the queue and the result
// register; buffer contents are not cleared. A stalled pop side holds the
// result register, then the engine, then fills the queue until full rises.
`timescale 1ns / 1ps

module path_glob_matcher #(
    parameter int PATTERN_DEPTH = 64,
    parameter int TEXT_DEPTH    = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  pgm_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output pgm_pkg::t_out_item o_result
);
    import pgm_pkg::*;

    logic      cmd_valid, cmd_ready;
    t_in_item  cmd;
    logic      res_valid, res_ready;
    t_out_item res;
    logic      r_out_vld;
    t_out_item r_out;

    pgm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_ready (cmd_ready)
    );

    pgm_engine #(
        .PATTERN_DEPTH (PATTERN_DEPTH),
        .TEXT_DEPTH    (TEXT_DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_ready (cmd_ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // Result register: refills in the cycle it is popped
    assign res_ready = !r_out_vld || pop;
    assign empty     = !r_out_vld;
    assign o_result  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_ready) begin
            r_out_vld <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

endmodule
